@@ rtl/core/nsp_pkg.sv @@
`timescale 1ns / 1ps
// shared constants, types and address helpers for the nmea sentence parser
package nsp_pkg;

    localparam int MAX_SENTENCE   = 100;
    localparam int MAX_TERMS      = 20;
    localparam int MAX_TERM_CHARS = 15;

    localparam int TERM_STRIDE = MAX_TERM_CHARS + 1;
    localparam int BANK_CHARS  = MAX_TERMS * TERM_STRIDE;
    localparam int CHAR_DEPTH  = 2 * BANK_CHARS;
    localparam int LEN_DEPTH   = 2 * MAX_TERMS;
    localparam int CHAR_AW     = $clog2(CHAR_DEPTH);
    localparam int LEN_AW      = $clog2(LEN_DEPTH);

    localparam int TERM_W   = 5;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = $clog2(MAX_SENTENCE + 3);
    localparam int PARITY_W = 14;

    localparam logic [7:0] BYTE_LF     = 8'h0A;
    localparam logic [7:0] BYTE_CR     = 8'h0D;
    localparam logic [7:0] BYTE_DOLLAR = 8'h24;
    localparam logic [7:0] BYTE_COMMA  = 8'h2C;
    localparam logic [7:0] BYTE_STAR   = 8'h2A;

    localparam logic CMD_FEED = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // write requests from the parser into the term store
    typedef struct packed {
        logic               char_we;
        logic [CHAR_AW-1:0] char_addr;
        logic [7:0]         char_data;
        logic               len_we;
        logic [LEN_AW-1:0]  len_addr;
        logic [POS_W-1:0]   len_data;
    } t_wr_req;

    // read request into the term store
    typedef struct packed {
        logic               re;
        logic [CHAR_AW-1:0] char_addr;
        logic [LEN_AW-1:0]  len_addr;
    } t_rd_req;

    // parser status seen by the top level
    typedef struct packed {
        logic              accept;
        logic [TERM_W-1:0] term_count_next;
        logic [TERM_W-1:0] term_count;
        logic              bank;
    } t_parse_status;

    function automatic logic [CHAR_AW-1:0] char_addr(
        input logic              bank,
        input logic [TERM_W-1:0] term,
        input logic [POS_W-1:0]  pos
    );
        logic [CHAR_AW-1:0] a;
        a = CHAR_AW'(term) * CHAR_AW'(TERM_STRIDE) + CHAR_AW'(pos);
        if (bank) begin
            a = a + CHAR_AW'(BANK_CHARS);
        end
        return a;
    endfunction

    function automatic logic [LEN_AW-1:0] len_addr(
        input logic              bank,
        input logic [TERM_W-1:0] term
    );
        logic [LEN_AW-1:0] a;
        a = LEN_AW'(term);
        if (bank) begin
            a = a + LEN_AW'(MAX_TERMS);
        end
        return a;
    endfunction

endpackage

@@ rtl/core/nsp_term_store.sv @@
`timescale 1ns / 1ps
// double-banked term character and term length memories
module nsp_term_store (
    input  logic                       i_clk,
    input  nsp_pkg::t_wr_req           i_wr,
    input  nsp_pkg::t_rd_req           i_rd,
    output logic [7:0]                 o_char,
    output logic [nsp_pkg::POS_W-1:0]  o_len
);

    logic [7:0]                r_chars [nsp_pkg::CHAR_DEPTH];
    logic [nsp_pkg::POS_W-1:0] r_lens  [nsp_pkg::LEN_DEPTH];
    logic [7:0]                r_char_q;
    logic [nsp_pkg::POS_W-1:0] r_len_q;

    always_ff @(posedge i_clk) begin
        if (i_wr.char_we) begin
            r_chars[i_wr.char_addr] <= i_wr.char_data;
        end
        if (i_rd.re) begin
            r_char_q <= r_chars[i_rd.char_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.len_we) begin
            r_lens[i_wr.len_addr] <= i_wr.len_data;
        end
        if (i_rd.re) begin
            r_len_q <= r_lens[i_rd.len_addr];
        end
    end

    assign o_char = r_char_q;
    assign o_len  = r_len_q;

endmodule

@@ rtl/core/nsp_parser.sv @@
`timescale 1ns / 1ps
// byte-level sentence framing, parity check and term store write control
module nsp_parser (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_feed,
    input  logic [7:0]             i_byte,
    output nsp_pkg::t_wr_req       o_wr,
    output nsp_pkg::t_parse_status o_status
);

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_BODY,
        PH_SUM_HI,
        PH_SUM_LO
    } t_phase;

    t_phase                         r_phase, n_phase, phase_eff;
    logic [nsp_pkg::COUNT_W-1:0]    r_char_count, n_char_count;
    logic [nsp_pkg::TERM_W-1:0]     r_term_index, n_term_index;
    logic [nsp_pkg::POS_W-1:0]      r_term_pos, n_term_pos;
    logic [nsp_pkg::POS_W-1:0]      r_eff_len, n_eff_len;
    logic                           r_zero_seen, n_zero_seen;
    logic [nsp_pkg::PARITY_W-1:0]   r_parity, n_parity;
    logic                           r_bank, n_bank;
    logic [nsp_pkg::TERM_W-1:0]     r_acc_terms, n_acc_terms;

    logic [nsp_pkg::PARITY_W-1:0]   sx_byte;
    logic [nsp_pkg::PARITY_W-1:0]   hex_val;
    logic [nsp_pkg::PARITY_W-1:0]   parity_lo;
    logic [nsp_pkg::POS_W-1:0]      put_eff;
    logic                           put_zero;
    logic                           accept;
    nsp_pkg::t_wr_req               wr;

    // sign-extended byte and unchecked hex digit value
    assign sx_byte = {{(nsp_pkg::PARITY_W-8){i_byte[7]}}, i_byte};
    assign hex_val = (!i_byte[7] && i_byte >= 8'd65)
                   ? nsp_pkg::PARITY_W'(i_byte - 8'd55)
                   : sx_byte - nsp_pkg::PARITY_W'(48);
    assign parity_lo = r_parity - hex_val;

    // effective length stops at the first zero byte
    assign put_zero = r_zero_seen || (i_byte == 8'h00);
    assign put_eff  = (!r_zero_seen && i_byte != 8'h00) ? r_eff_len + 1'b1 : r_eff_len;

    always_comb begin
        phase_eff = r_phase;
        if (r_char_count >= nsp_pkg::COUNT_W'(nsp_pkg::MAX_SENTENCE)
            || r_term_index >= nsp_pkg::TERM_W'(nsp_pkg::MAX_TERMS)
            || r_term_pos >= nsp_pkg::POS_W'(nsp_pkg::MAX_TERM_CHARS)) begin
            phase_eff = PH_WAIT;
        end
        if (i_byte == nsp_pkg::BYTE_LF || i_byte == nsp_pkg::BYTE_CR) begin
            phase_eff = PH_WAIT;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_char_count = r_char_count;
        n_term_index = r_term_index;
        n_term_pos   = r_term_pos;
        n_eff_len    = r_eff_len;
        n_zero_seen  = r_zero_seen;
        n_parity     = r_parity;
        n_bank       = r_bank;
        n_acc_terms  = r_acc_terms;
        accept       = 1'b0;
        wr           = '0;
        wr.char_addr = nsp_pkg::char_addr(~r_bank, r_term_index, r_term_pos);
        wr.char_data = i_byte;
        wr.len_addr  = nsp_pkg::len_addr(~r_bank, r_term_index);
        wr.len_data  = r_eff_len;

        if (i_feed) begin
            n_phase = phase_eff;
            if (i_byte == nsp_pkg::BYTE_DOLLAR) begin
                n_parity     = '0;
                n_term_index = '0;
                n_term_pos   = '0;
                n_eff_len    = '0;
                n_zero_seen  = 1'b0;
                n_char_count = nsp_pkg::COUNT_W'(1);
                n_phase      = PH_BODY;
            end else begin
                case (phase_eff)
                    PH_BODY: begin
                        n_char_count = r_char_count + 1'b1;
                        if (i_byte == nsp_pkg::BYTE_COMMA
                            || i_byte == nsp_pkg::BYTE_STAR) begin
                            // close the term
                            wr.len_we    = r_term_index < nsp_pkg::TERM_W'(nsp_pkg::MAX_TERMS);
                            n_term_index = r_term_index + 1'b1;
                            n_term_pos   = '0;
                            n_eff_len    = '0;
                            n_zero_seen  = 1'b0;
                            if (i_byte == nsp_pkg::BYTE_COMMA) begin
                                n_parity = r_parity ^ sx_byte;
                            end else begin
                                n_phase = PH_SUM_HI;
                            end
                        end else begin
                            wr.char_we  = r_term_index < nsp_pkg::TERM_W'(nsp_pkg::MAX_TERMS);
                            n_term_pos  = r_term_pos + 1'b1;
                            n_eff_len   = put_eff;
                            n_zero_seen = put_zero;
                            n_parity    = r_parity ^ sx_byte;
                        end
                    end
                    PH_SUM_HI: begin
                        n_char_count = r_char_count + 1'b1;
                        wr.char_we   = r_term_index < nsp_pkg::TERM_W'(nsp_pkg::MAX_TERMS);
                        n_term_pos   = r_term_pos + 1'b1;
                        n_eff_len    = put_eff;
                        n_zero_seen  = put_zero;
                        n_parity     = r_parity - {hex_val[nsp_pkg::PARITY_W-5:0], 4'b0000};
                        n_phase      = PH_SUM_LO;
                    end
                    PH_SUM_LO: begin
                        n_char_count = r_char_count + 2'd2;
                        wr.char_we   = r_term_index < nsp_pkg::TERM_W'(nsp_pkg::MAX_TERMS);
                        wr.len_we    = r_term_index < nsp_pkg::TERM_W'(nsp_pkg::MAX_TERMS);
                        wr.len_data  = put_eff;
                        n_term_index = r_term_index + 1'b1;
                        n_term_pos   = '0;
                        n_eff_len    = '0;
                        n_zero_seen  = 1'b0;
                        n_parity     = parity_lo;
                        n_phase      = PH_WAIT;
                        if (parity_lo == '0) begin
                            accept      = 1'b1;
                            n_bank      = ~r_bank;
                            n_acc_terms = r_term_index + 1'b1;
                        end
                    end
                    default: begin
                        n_phase = PH_WAIT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_WAIT;
            r_char_count <= '0;
            r_term_index <= '0;
            r_term_pos   <= '0;
            r_eff_len    <= '0;
            r_zero_seen  <= 1'b0;
            r_parity     <= '0;
            r_bank       <= 1'b0;
            r_acc_terms  <= '0;
        end else begin
            r_phase      <= n_phase;
            r_char_count <= n_char_count;
            r_term_index <= n_term_index;
            r_term_pos   <= n_term_pos;
            r_eff_len    <= n_eff_len;
            r_zero_seen  <= n_zero_seen;
            r_parity     <= n_parity;
            r_bank       <= n_bank;
            r_acc_terms  <= n_acc_terms;
        end
    end

    assign o_wr                     = wr;
    assign o_status.accept          = accept;
    assign o_status.term_count_next = n_acc_terms;
    assign o_status.term_count      = r_acc_terms;
    assign o_status.bank            = r_bank;

endmodule

@@ rtl/core/nmea_sentence_parser_unit.sv @@
`timescale 1ns / 1ps
// top level of the nmea sentence parser: handshake, read pipeline and checks
//
// Each input word either feeds one received byte (cmd 0) or reads one character
// of the last accepted sentence (cmd 1). A '$' starts a sentence; bytes are split
// into terms at ',' and folded into an XOR parity up to '*'; the two hex digits
// after '*' are subtracted and a zero result accepts the sentence. CR, LF or an
// overrun of 100 characters, 20 terms or 15 characters per term drops the
// sentence. Terms are written into the idle half of a double-banked memory, so
// acceptance is a bank swap and needs no copy. One word is taken every clock
// cycle unless the result channel stalls; each word gives exactly one result
// word, via the synchronous term memory read in stage 1 and the output register.
// A read returns the term length and the requested character, both 0 past the
// term count, and the character 0 past the term end. The memories need no
// clearing after reset, and reads only reach terms that a sentence wrote.
module nmea_sentence_parser_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_cmd,
    input  logic [7:0] i_data_byte,
    input  logic [4:0] i_term_sel,
    input  logic [3:0] i_char_sel,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_accepted,
    output logic [4:0] o_term_count,
    output logic [7:0] o_read_char,
    output logic [3:0] o_read_length
);

    logic                      in_fire;
    logic                      advance;
    logic                      term_ok;
    nsp_pkg::t_wr_req          wr;
    nsp_pkg::t_rd_req          rd;
    nsp_pkg::t_parse_status    status;
    logic [7:0]                mem_char;
    logic [nsp_pkg::POS_W-1:0] mem_len;

    // stage 1: memory read in flight
    logic                      r_s1_valid;
    logic                      r_s1_read;
    logic                      r_s1_accepted;
    logic [4:0]                r_s1_count;
    logic                      r_s1_term_ok;
    logic [3:0]                r_s1_char_sel;

    // output register
    logic                      r_out_valid;
    logic                      r_accepted;
    logic [4:0]                r_term_count;
    logic [7:0]                r_read_char;
    logic [3:0]                r_read_length;

    // stage 1 moves on when the output register is free or being drained
    assign advance    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    // a read only reaches terms of the readable bank that the last sentence wrote
    assign term_ok = (i_term_sel < status.term_count)
                  && (i_term_sel < 5'(nsp_pkg::MAX_TERMS));

    assign rd.re        = in_fire && (i_cmd == nsp_pkg::CMD_READ) && term_ok;
    assign rd.char_addr = nsp_pkg::char_addr(status.bank, i_term_sel, i_char_sel);
    assign rd.len_addr  = nsp_pkg::len_addr(status.bank, i_term_sel);

    nsp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_feed   (in_fire && (i_cmd == nsp_pkg::CMD_FEED)),
        .i_byte   (i_data_byte),
        .o_wr     (wr),
        .o_status (status)
    );

    // feeds write the working bank, reads see the other one, so no overlap
    nsp_term_store u_store (
        .i_clk  (i_clk),
        .i_wr   (wr),
        .i_rd   (rd),
        .o_char (mem_char),
        .o_len  (mem_len)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_read     <= (i_cmd == nsp_pkg::CMD_READ);
            r_s1_accepted <= status.accept;
            r_s1_count    <= status.term_count_next;
            r_s1_term_ok  <= term_ok;
            r_s1_char_sel <= i_char_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // stored length already stops at the first zero byte
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_accepted    <= r_s1_accepted;
            r_term_count  <= r_s1_count;
            r_read_length <= (r_s1_read && r_s1_term_ok) ? mem_len : 4'd0;
            r_read_char   <= (r_s1_read && r_s1_term_ok && (r_s1_char_sel < mem_len))
                           ? mem_char : 8'd0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_accepted    = r_accepted;
    assign o_term_count  = r_term_count;
    assign o_read_char   = r_read_char;
    assign o_read_length = r_read_length;

    // an accepted sentence always holds at least the checksum term
    a_accept_has_terms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_accepted) |-> (o_term_count != 5'd0))
        else $error("accepted sentence with no terms");

    // an accepting feed never returns read data
    a_accept_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_accepted) |-> (o_read_length == 4'd0 && o_read_char == 8'd0))
        else $error("read data on an accepting feed");

    // a returned character lies inside its term, which holds no zero byte
    a_char_in_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_read_char != 8'd0) |-> (o_read_length != 4'd0))
        else $error("character returned from an empty term");

    // a stalled stage 1 keeps its word until the output register takes it
    a_s1_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !advance) |=> (r_s1_valid && $stable(r_s1_count)
                                      && $stable(r_s1_accepted)))
        else $error("stage 1 word lost while stalled");

    // term count never exceeds the term limit
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_term_count <= 5'(nsp_pkg::MAX_TERMS)))
        else $error("term count out of range");

endmodule
